### rtl/jse_pkg.sv
// Shared types, constants and helper functions of the JSON string escaper.
`default_nettype none
package jse_pkg;

	localparam int MAX_RESULTS = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_U   = 8'h75;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_2   = 8'h32;
	localparam logic [7:0] CH_DIGIT_8   = 8'h38;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] UTF_LEAD     = 8'hE2;
	localparam logic [7:0] UTF_MID      = 8'h80;
	localparam logic [7:0] UTF_LINE_SEP = 8'hA8;
	localparam logic [7:0] UTF_PARA_SEP = 8'hA9;

	localparam logic [1:0] HELD_NONE     = 2'd0;
	localparam logic [1:0] HELD_LEAD     = 2'd1;
	localparam logic [1:0] HELD_LEAD_MID = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       string_start;
		logic       string_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       item_done;
		logic       string_done;
	} result_t;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [2:0]                  count;
		logic                        closing;
	} cmd_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h37 + {4'd0, nib};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/jse_front.sv
// Front end: accepts items, tracks the held UTF-8 prefix and builds the output byte list.
`default_nettype none
module jse_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire jse_pkg::item_t  item,
	output jse_pkg::cmd_t        cmd,
	output logic                 cmd_valid
);
	import jse_pkg::*;

	logic [1:0] held_q;
	logic [1:0] held_d;

	always_comb begin
		logic [2:0] n;
		logic [1:0] held;
		logic       fresh;
		logic [7:0] b;
		n = 3'd0;
		cmd = '0;
		b = item.data_byte;
		held = (held_q == HELD_LEAD || held_q == HELD_LEAD_MID) ? held_q : HELD_NONE;
		fresh = item.has_byte;
		if (item.string_start) begin
			held = HELD_NONE;
			cmd.bytes[n] = CH_QUOTE; n = n + 3'd1;
		end
		if (item.has_byte) begin
			if (held == HELD_LEAD && b == UTF_MID) begin
				held = HELD_LEAD_MID;
				fresh = 1'b0;
			end else if (held == HELD_LEAD_MID && (b == UTF_LINE_SEP || b == UTF_PARA_SEP)) begin
				cmd.bytes[n] = CH_BACKSLASH; n = n + 3'd1;
				cmd.bytes[n] = CH_LOWER_U; n = n + 3'd1;
				cmd.bytes[n] = CH_DIGIT_2; n = n + 3'd1;
				cmd.bytes[n] = CH_DIGIT_0; n = n + 3'd1;
				cmd.bytes[n] = CH_DIGIT_2; n = n + 3'd1;
				cmd.bytes[n] = (b == UTF_LINE_SEP) ? CH_DIGIT_8 : CH_DIGIT_9; n = n + 3'd1;
				held = HELD_NONE;
				fresh = 1'b0;
			end else begin
				if (held != HELD_NONE) begin
					cmd.bytes[n] = UTF_LEAD; n = n + 3'd1;
				end
				if (held == HELD_LEAD_MID) begin
					cmd.bytes[n] = UTF_MID; n = n + 3'd1;
				end
				held = HELD_NONE;
			end
		end
		if (fresh) begin
			unique case (b)
				CH_NEWLINE: begin
					cmd.bytes[n] = CH_BACKSLASH; n = n + 3'd1;
					cmd.bytes[n] = CH_LOWER_N; n = n + 3'd1;
				end
				CH_RETURN: begin
					cmd.bytes[n] = CH_BACKSLASH; n = n + 3'd1;
					cmd.bytes[n] = CH_LOWER_R; n = n + 3'd1;
				end
				CH_TAB: begin
					cmd.bytes[n] = CH_BACKSLASH; n = n + 3'd1;
					cmd.bytes[n] = CH_LOWER_T; n = n + 3'd1;
				end
				CH_QUOTE, CH_BACKSLASH: begin
					cmd.bytes[n] = CH_BACKSLASH; n = n + 3'd1;
					cmd.bytes[n] = b; n = n + 3'd1;
				end
				UTF_LEAD: begin
					held = HELD_LEAD;
				end
				default: begin
					if (b < CH_SPACE) begin
						cmd.bytes[n] = CH_BACKSLASH; n = n + 3'd1;
						cmd.bytes[n] = CH_LOWER_X; n = n + 3'd1;
						cmd.bytes[n] = hex_digit(b[7:4]); n = n + 3'd1;
						cmd.bytes[n] = hex_digit(b[3:0]); n = n + 3'd1;
					end else begin
						cmd.bytes[n] = b; n = n + 3'd1;
					end
				end
			endcase
		end
		if (item.string_end) begin
			if (held != HELD_NONE) begin
				cmd.bytes[n] = UTF_LEAD; n = n + 3'd1;
			end
			if (held == HELD_LEAD_MID) begin
				cmd.bytes[n] = UTF_MID; n = n + 3'd1;
			end
			held = HELD_NONE;
			cmd.bytes[n] = CH_QUOTE; n = n + 3'd1;
			cmd.closing = 1'b1;
		end
		cmd.count = n;
		held_d = held;
	end

	assign cmd_valid = accept && (cmd.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

### rtl/jse_queue.sv
// Short queue of byte lists between the front end and the back end.
`default_nettype none
module jse_queue #(
	parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire jse_pkg::cmd_t  wr_cmd,
	output logic                full,
	input  wire                 rd_en,
	output jse_pkg::cmd_t       rd_cmd,
	output logic                rd_valid
);
	import jse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/jse_back.sv
// Back end: walks each byte list and presents one result at a time in an output register.
`default_nettype none
module jse_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire jse_pkg::cmd_t  cmd,
	input  wire                 cmd_valid,
	output logic                cmd_pop,
	output jse_pkg::result_t    result,
	output logic                empty,
	input  wire                 pop
);
	import jse_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	result_t    result_q;
	logic       load;
	logic       last;

	assign load    = cmd_valid && (!valid_q || pop);
	assign last    = (idx_q == cmd.count - 3'd1);
	assign cmd_pop = load && last;
	assign result  = result_q;
	assign empty   = !valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.out_byte    <= cmd.bytes[idx_q];
			result_q.item_done   <= last;
			result_q.string_done <= last && cmd.closing;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/json_string_escaper.sv
// Top level of the JSON string escaper: front end, byte-list queue and back end.
// An accepted item is written to the queue, then its first result is loaded into the output register.
// Throughput: while pop is held high, the back end emits one result per cycle from its output register,
// and plain bytes stream at one item per cycle.
// The queue between front and back end lets new items enter while escapes are expanded.
// Reset clears the held prefix, the queue and the output valid flag at once.
`default_nettype none
module json_string_escaper #(
	parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  wire jse_pkg::item_t  item,
	output logic                 empty,
	input  wire                  pop,
	output jse_pkg::result_t     result
);
	import jse_pkg::*;

	cmd_t front_cmd;
	logic front_valid;
	cmd_t head_cmd;
	logic head_valid;
	logic head_pop;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push && !full),
		.item      (item),
		.cmd       (front_cmd),
		.cmd_valid (front_valid)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_cmd   (front_cmd),
		.full     (full),
		.rd_en    (head_pop),
		.rd_cmd   (head_cmd),
		.rd_valid (head_valid)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (head_valid),
		.cmd_pop   (head_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
`default_nettype wire

### bench/tb_top.sv
// Testbench of the JSON string escaper: directed and random strings checked against a predictor.
`timescale 1ns / 100ps
module tb_top;
	import jse_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 200;
	localparam int SETTLE       = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	class escape_checker;
		result_t escaped_q[$];
		result_t batch[$];
		logic [1:0] held;
		int errors;
		int n_items;
		int n_bytes;
		int n_seps;
		int n_flushes;

		function new();
			held = HELD_NONE;
		endfunction

		function void emit(input logic [7:0] b, input logic closing);
			result_t r;
			r.out_byte = b;
			r.item_done = 1'b0;
			r.string_done = closing;
			batch.insert(batch.size(), r);
		endfunction

		function logic [7:0] hex_char(input logic [3:0] nib);
			if (nib < 4'd10) begin
				return CH_DIGIT_0 + {4'd0, nib};
			end
			return CH_UPPER_A + {4'd0, nib} - 8'd10;
		endfunction

		function void flush_prefix();
			if (held == HELD_LEAD) begin
				emit(UTF_LEAD, 1'b0);
				n_flushes++;
			end else if (held == HELD_LEAD_MID) begin
				emit(UTF_LEAD, 1'b0);
				emit(UTF_MID, 1'b0);
				n_flushes++;
			end
			held = HELD_NONE;
		endfunction

		function void fresh_byte(input logic [7:0] b);
			case (b)
				CH_NEWLINE: begin
					emit(CH_BACKSLASH, 1'b0);
					emit(CH_LOWER_N, 1'b0);
				end
				CH_RETURN: begin
					emit(CH_BACKSLASH, 1'b0);
					emit(CH_LOWER_R, 1'b0);
				end
				CH_TAB: begin
					emit(CH_BACKSLASH, 1'b0);
					emit(CH_LOWER_T, 1'b0);
				end
				CH_QUOTE: begin
					emit(CH_BACKSLASH, 1'b0);
					emit(CH_QUOTE, 1'b0);
				end
				CH_BACKSLASH: begin
					emit(CH_BACKSLASH, 1'b0);
					emit(CH_BACKSLASH, 1'b0);
				end
				default: begin
					if (b < CH_SPACE) begin
						emit(CH_BACKSLASH, 1'b0);
						emit(CH_LOWER_X, 1'b0);
						emit(hex_char(b[7:4]), 1'b0);
						emit(hex_char(b[3:0]), 1'b0);
					end else if (b == UTF_LEAD) begin
						held = HELD_LEAD;
					end else begin
						emit(b, 1'b0);
					end
				end
			endcase
		endfunction

		function void separator(input logic [7:0] last);
			emit(CH_BACKSLASH, 1'b0);
			emit(CH_LOWER_U, 1'b0);
			emit(CH_DIGIT_2, 1'b0);
			emit(CH_DIGIT_0, 1'b0);
			emit(CH_DIGIT_2, 1'b0);
			emit(last, 1'b0);
			n_seps++;
		endfunction

		function void take_byte(input logic [7:0] b);
			if (held == HELD_LEAD) begin
				if (b == UTF_MID) begin
					held = HELD_LEAD_MID;
					return;
				end
				flush_prefix();
			end else if (held == HELD_LEAD_MID) begin
				if (b == UTF_LINE_SEP || b == UTF_PARA_SEP) begin
					held = HELD_NONE;
					separator(b == UTF_LINE_SEP ? CH_DIGIT_8 : CH_DIGIT_9);
					return;
				end
				flush_prefix();
			end
			fresh_byte(b);
		endfunction

		function void note_item(input item_t it);
			batch.delete();
			n_items++;
			if (held > HELD_LEAD_MID) begin
				held = HELD_NONE;
			end
			if (it.string_start) begin
				held = HELD_NONE;
				emit(CH_QUOTE, 1'b0);
			end
			if (it.has_byte) begin
				take_byte(it.data_byte);
			end
			if (it.string_end) begin
				flush_prefix();
				emit(CH_QUOTE, 1'b1);
			end
			if (batch.size() > 0) begin
				batch[batch.size() - 1].item_done = 1'b1;
			end
			foreach (batch[i]) begin
				escaped_q.insert(escaped_q.size(), batch[i]);
			end
		endfunction

		function void check_byte(input result_t got);
			result_t want;
			if (escaped_q.size() == 0) begin
				$error("unexpected result: out_byte %h item_done %b string_done %b",
					got.out_byte, got.item_done, got.string_done);
				errors++;
				return;
			end
			want = escaped_q.pop_front();
			n_bytes++;
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.item_done !== want.item_done) begin
				$error("item_done: expected %b, actual %b", want.item_done, got.item_done);
				errors++;
			end
			if (got.string_done !== want.string_done) begin
				$error("string_done: expected %b, actual %b", want.string_done, got.string_done);
				errors++;
			end
		endfunction

		function int pending();
			return escaped_q.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	escape_checker board = new();
	bit tx_idle_en;
	bit rx_idle_en;
	bit hold_rx;
	int items_sent;
	int stall_cycles;
	int cycle_count;

	json_string_escaper u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				board.note_item(item);
			end
			if (push && full) begin
				stall_cycles++;
			end
			if (pop && !empty) begin
				board.check_byte(result);
			end
		end
	end

	function automatic item_t mk(input logic [7:0] b, input logic h, input logic s,
		input logic e);
		item_t it;
		it.data_byte = b;
		it.has_byte = h;
		it.string_start = s;
		it.string_end = e;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		if (it.has_byte || it.string_start || it.string_end) begin
			items_sent++;
		end
	endtask

	task automatic send_string();
		int len;
		int last;
		logic [7:0] text[$];
		bit merge_first;
		bit merge_last;
		bit drop_start;
		bit drop_end;
		len = $urandom_range(0, 10);
		while (text.size() < len) begin
			case ($urandom_range(0, 9))
				0: begin
					text.insert(text.size(), UTF_LEAD);
					text.insert(text.size(), UTF_MID);
					text.insert(text.size(),
						$urandom_range(0, 1) ? UTF_LINE_SEP : UTF_PARA_SEP);
				end
				1: text.insert(text.size(), UTF_LEAD);
				2: begin
					text.insert(text.size(), UTF_LEAD);
					text.insert(text.size(), UTF_MID);
				end
				3: text.insert(text.size(), 8'($urandom_range(0, 31)));
				4: begin
					case ($urandom_range(0, 4))
						0: text.insert(text.size(), CH_NEWLINE);
						1: text.insert(text.size(), CH_RETURN);
						2: text.insert(text.size(), CH_TAB);
						3: text.insert(text.size(), CH_QUOTE);
						default: text.insert(text.size(), CH_BACKSLASH);
					endcase
				end
				5: text.insert(text.size(), 8'($urandom_range(128, 255)));
				default: text.insert(text.size(), 8'($urandom_range(32, 126)));
			endcase
		end
		last = text.size() - 1;
		drop_start = ($urandom_range(0, 9) == 0);
		drop_end = ($urandom_range(0, 9) == 0);
		merge_first = (text.size() > 0) && ($urandom_range(0, 1) == 1);
		merge_last = (text.size() > 0) && ($urandom_range(0, 1) == 1);
		if (!merge_first && !drop_start) begin
			send_item(mk(8'($urandom), 1'b0, 1'b1, 1'b0));
		end
		foreach (text[k]) begin
			send_item(mk(text[k], 1'b1, merge_first && !drop_start && k == 0,
				merge_last && !drop_end && k == last));
		end
		if (!merge_last && !drop_end) begin
			send_item(mk(8'($urandom), 1'b0, 1'b0, 1'b1));
		end
	endtask

	task automatic random_traffic(input int upto);
		while (items_sent < upto) begin
			case ($urandom_range(0, 9))
				7, 8: send_item(mk(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
				9: send_item(mk(8'($urandom), 1'b0, 1'b0, 1'b0));
				default: send_string();
			endcase
		end
	endtask

	initial begin
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_rx = 1'b0;
		items_sent = 0;
		stall_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(mk(8'h00, 1'b0, 1'b1, 1'b0));
		send_item(mk(8'h00, 1'b1, 1'b0, 1'b0));
		send_item(mk(8'h1F, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_SPACE, 1'b1, 1'b0, 1'b0));
		send_item(mk(8'hFF, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_NEWLINE, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_RETURN, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_TAB, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_QUOTE, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_BACKSLASH, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_MID, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_LINE_SEP, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_MID, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_PARA_SEP, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_MID, 1'b1, 1'b0, 1'b0));
		send_item(mk(8'h05, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b1));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b0));
		send_item(mk(UTF_MID, 1'b1, 1'b0, 1'b0));
		send_item(mk(8'h01, 1'b1, 1'b0, 1'b1));
		send_item(mk(8'hFF, 1'b0, 1'b0, 1'b0));
		send_item(mk(UTF_LEAD, 1'b1, 1'b0, 1'b0));
		send_item(mk(CH_UPPER_A, 1'b1, 1'b1, 1'b0));
		send_item(mk(CH_BACKSLASH, 1'b1, 1'b0, 1'b1));

		random_traffic(items_sent + RANDOM_ITEMS * 2 / 3);

		tx_idle_en = 1'b0;
		hold_rx = 1'b1;
		repeat (4) send_string();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);

		tx_idle_en = 1'b1;
		random_traffic(items_sent + RANDOM_ITEMS / 6);

		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		random_traffic(items_sent + RANDOM_ITEMS / 6);
		push <= 1'b0;
		@(posedge clk);

		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("tb: %0d items sent, %0d output bytes checked, %0d input stall cycles",
			board.n_items, board.n_bytes, stall_cycles);
		$display("tb: %0d separators escaped, %0d partial prefixes passed through raw",
			board.n_seps, board.n_flushes);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
